[hw/rtl/mbab_pkg.sv]
package mbab_pkg;

    // Default build limits
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam int DEF_MAX_WINDOW = 31;

    // Configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BLUR_SIZE    = 2'd2;

    localparam int IMAGE_WIDTH_W  = 12;
    localparam int IMAGE_HEIGHT_W = 12;
    localparam int BLUR_SIZE_W    = 5;

    localparam logic [IMAGE_WIDTH_W-1:0]  IMAGE_WIDTH_RST  = 12'd640;
    localparam logic [IMAGE_HEIGHT_W-1:0] IMAGE_HEIGHT_RST = 12'd480;
    localparam logic [BLUR_SIZE_W-1:0]    BLUR_SIZE_RST    = 5'd5;

    // Item opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Blend arithmetic
    localparam int         ALPHA_W     = 8;
    localparam logic [7:0] ALPHA_MAX   = 8'd255;
    localparam int         BLEND_ROUND = 127;
    localparam int         RECIP_255   = 257;

    // Stored pixel: original r, g, b then inpainted r, g, b
    localparam int PIX_W = 48;
    typedef logic [PIX_W-1:0] pix_word_t;

endpackage

[hw/rtl/mbab_if.sv]
interface mbab_pix_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] orig_red;
    logic [7:0] orig_green;
    logic [7:0] orig_blue;
    logic [7:0] fill_red;
    logic [7:0] fill_green;
    logic [7:0] fill_blue;
    logic [7:0] mask_value;

    modport source (
        output valid, opcode, orig_red, orig_green, orig_blue,
               fill_red, fill_green, fill_blue, mask_value,
        input  ready
    );
    modport sink (
        input  valid, opcode, orig_red, orig_green, orig_blue,
               fill_red, fill_green, fill_blue, mask_value,
        output ready
    );
endinterface

interface mbab_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_end;

    modport source (
        output valid, out_red, out_green, out_blue, frame_end,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue, frame_end,
        output ready
    );
endinterface

[hw/rtl/mbab_cfg.sv]
module mbab_cfg
    import mbab_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW,
    localparam int WW     = $clog2(MAX_WIDTH + 1),
    localparam int HW     = $clog2(MAX_HEIGHT + 1),
    localparam int KW     = $clog2(MAX_WINDOW + 1),
    localparam int CW     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
    localparam int AREA_W = $clog2(MAX_WINDOW * MAX_WINDOW + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [WW-1:0]         frame_w,
    output logic [HW-1:0]         frame_h,
    output logic [KW-1:0]         frame_k,
    output logic [CW-1:0]         frame_total,
    output logic [CW-1:0]         frame_lag,
    output logic [AREA_W-1:0]     frame_area
);

    logic [IMAGE_WIDTH_W-1:0]  width_reg;
    logic [IMAGE_HEIGHT_W-1:0] height_reg;
    logic [BLUR_SIZE_W-1:0]    blur_reg;
    logic [WW-1:0]             fw_reg;
    logic [HW-1:0]             fh_reg;
    logic [KW-1:0]             fk_reg;
    logic [CW-1:0]             total_reg;
    logic [CW-1:0]             lag_reg;
    logic [AREA_W-1:0]         area_reg;
    logic [WW-1:0]             fw_next;
    logic [HW-1:0]             fh_next;
    logic [KW-1:0]             fk_next;
    logic [KW-1:0]             half;
    logic                      wr_en;
    logic [1:0]                reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= IMAGE_WIDTH_RST;
            height_reg <= IMAGE_HEIGHT_RST;
            blur_reg   <= BLUR_SIZE_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[IMAGE_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[IMAGE_HEIGHT_W-1:0];
                REG_BLUR_SIZE:    blur_reg   <= pwdata[BLUR_SIZE_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(height_reg);
            REG_BLUR_SIZE:    prdata = APB_DATA_W'(blur_reg);
            default:          prdata = '0;
        endcase
    end

    // Clamp to the legal range of each register
    always_comb
    begin
        if (width_reg == '0)
            fw_next = WW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            fw_next = WW'(MAX_WIDTH);
        else
            fw_next = WW'(width_reg);

        if (height_reg == '0)
            fh_next = HW'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            fh_next = HW'(MAX_HEIGHT);
        else
            fh_next = HW'(height_reg);

        if (blur_reg == '0)
            fk_next = KW'(1);
        else if (32'(blur_reg) > MAX_WINDOW)
            fk_next = KW'(MAX_WINDOW);
        else
            fk_next = KW'(blur_reg);
    end

    assign half = fk_next >> 1;

    // One register stage: clamped values and frame products settle together
    always_ff @(posedge clk)
    begin
        fw_reg    <= fw_next;
        fh_reg    <= fh_next;
        fk_reg    <= fk_next;
        total_reg <= CW'(fw_next) * CW'(fh_next);
        lag_reg   <= CW'(half) * CW'(fw_next) + CW'(half);
        area_reg  <= AREA_W'(fk_next) * AREA_W'(fk_next);
    end

    assign frame_w     = fw_reg;
    assign frame_h     = fh_reg;
    assign frame_k     = fk_reg;
    assign frame_total = total_reg;
    assign frame_lag   = lag_reg;
    assign frame_area  = area_reg;

endmodule

[hw/rtl/mbab_line_store.sv]
module mbab_line_store
    import mbab_pkg::*;
#(
    parameter int ADDR_W = 16
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        mask_wdata,
    input  pix_word_t         pix_wdata,
    input  logic              mask_re,
    input  logic [ADDR_W-1:0] mask_raddr,
    output logic [7:0]        mask_rdata,
    input  logic              pix_re,
    input  logic [ADDR_W-1:0] pix_raddr,
    output pix_word_t         pix_rdata
);

    logic [7:0] mask_mem [2**ADDR_W];
    pix_word_t  pix_mem  [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
            mask_mem[waddr] <= mask_wdata;
        if (mask_re)
            mask_rdata <= mask_mem[mask_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we)
            pix_mem[waddr] <= pix_wdata;
        if (pix_re)
            pix_rdata <= pix_mem[pix_raddr];
    end

endmodule

[hw/rtl/mbab_div.sv]
module mbab_div
    import mbab_pkg::*;
#(
    parameter int NUM_W = 22,
    parameter int DEN_W = 11
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [NUM_W-1:0]   num,
    input  logic [DEN_W-1:0]   den,
    output logic               done,
    output logic [ALPHA_W-1:0] quot
);

    localparam int XW  = (NUM_W > DEN_W + ALPHA_W - 1) ? NUM_W : DEN_W + ALPHA_W - 1;
    localparam int CNW = $clog2(ALPHA_W);

    logic [XW-1:0]      rem_reg;
    logic [XW-1:0]      div_reg;
    logic [ALPHA_W-1:0] quot_reg;
    logic [CNW-1:0]     cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic               fits;

    assign fits = (rem_reg >= div_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNW'(1);
                if (cnt_reg == CNW'(ALPHA_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // One quotient bit a cycle, most significant first
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= XW'(num);
            div_reg <= XW'(den) << (ALPHA_W - 1);
        end
        else if (busy_reg)
        begin
            if (fits)
                rem_reg <= rem_reg - div_reg;
            quot_reg <= {quot_reg[ALPHA_W-2:0], fits};
            div_reg  <= div_reg >> 1;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

[hw/rtl/mbab_blend.sv]
module mbab_blend
    import mbab_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [ALPHA_W-1:0] alpha,
    input  pix_word_t          pix,
    output logic               done,
    output logic [7:0]         red,
    output logic [7:0]         green,
    output logic [7:0]         blue
);

    logic        s1_reg;
    logic        s2_reg;
    logic        done_reg;
    logic [15:0] pa_reg [3];
    logic [15:0] pb_reg [3];
    logic [16:0] x_reg  [3];
    logic [25:0] e_reg  [3];
    logic [7:0]  q_reg  [3];
    logic [16:0] x_next [3];
    logic [8:0]  q_est  [3];
    logic [16:0] r_est  [3];
    logic [8:0]  q_fix  [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg   <= 1'b0;
            s2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_reg   <= start;
            s2_reg   <= s1_reg;
            done_reg <= s2_reg;
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            x_next[c] = 17'(pa_reg[c]) + 17'(pb_reg[c]) + 17'(BLEND_ROUND);
            // x / 255: reciprocal estimate is low by at most one
            q_est[c]  = e_reg[c][24:16];
            r_est[c]  = x_reg[c] - (17'({q_est[c], 8'b0}) - 17'(q_est[c]));
            q_fix[c]  = (r_est[c] >= 17'(ALPHA_MAX)) ? q_est[c] + 9'd1 : q_est[c];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (start)
            begin
                pa_reg[c] <= 16'(alpha) * 16'(pix[PIX_W-1-8*c -: 8]);
                pb_reg[c] <= 16'(ALPHA_MAX - alpha) * 16'(pix[PIX_W/2-1-8*c -: 8]);
            end
            if (s1_reg)
            begin
                x_reg[c] <= x_next[c];
                e_reg[c] <= 26'(x_next[c]) * 26'(RECIP_255);
            end
            if (s2_reg)
                q_reg[c] <= (q_fix[c] > 9'(ALPHA_MAX)) ? ALPHA_MAX : q_fix[c][7:0];
        end
    end

    assign done  = done_reg;
    assign red   = q_reg[0];
    assign green = q_reg[1];
    assign blue  = q_reg[2];

endmodule

[hw/rtl/masked_border_alpha_blend.sv]
// Channel   Kind        Direction  Payload
// pixels    valid/ready in         opcode, original rgb, inpainted rgb, mask byte
// results   valid/ready out        blended rgb, frame_end
// apb       psel/penable in/out    image_width, image_height, blur_size
//
// Sequence: a flush with no frame open is dropped in S_IDLE. Any other item
// passes S_STORE and S_CHECK (after S_START on the first pixel of a frame).
// An item that gives a result then folds the window corner back into the
// frame in S_REFL, reads the k*k mask taps one a cycle through the single
// read port of the mask line store, then a divider forms alpha and a 3-stage
// blend pipe forms the colors.
// Reset: rst_n clears the sequencer, counters and output valid at once; the
// line stores are not cleared, every entry is written before it is read.
// Stalls: a finished result waits in the output register while the next item
// is taken; the sequencer holds before its own load until that register frees.
module masked_border_alpha_blend
    import mbab_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    mbab_pix_if.sink              pixels,
    mbab_res_if.source            results,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int KW     = $clog2(MAX_WINDOW + 1);
    localparam int CW     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int AREA_W = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
    localparam int SUM_W  = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
    localparam int NUM_W  = SUM_W + 2;
    localparam int DEN_W  = AREA_W + 1;
    localparam int CB     = $clog2(MAX_WIDTH);
    localparam int RB     = $clog2(2 * (MAX_WINDOW / 2) + 2);
    localparam int RWB    = $clog2(MAX_HEIGHT);
    localparam int RWW    = (RWB > RB) ? RWB : RB;
    localparam int ADDR_W = RB + CB;
    localparam int DIM_W  = (WW > HW) ? WW : HW;
    localparam int PW     = ((DIM_W > KW) ? DIM_W : KW) + 2;

    localparam logic signed [PW-1:0] P_ZERO = '0;
    localparam logic signed [PW-1:0] P_ONE  = PW'(1);

    localparam logic DIR_UP   = 1'b0;
    localparam logic DIR_DOWN = 1'b1;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_START   = 4'd1;
    localparam logic [3:0] S_STORE   = 4'd2;
    localparam logic [3:0] S_CHECK   = 4'd3;
    localparam logic [3:0] S_REFL    = 4'd4;
    localparam logic [3:0] S_ACC     = 4'd5;
    localparam logic [3:0] S_PIX     = 4'd6;
    localparam logic [3:0] S_LOADPIX = 4'd7;
    localparam logic [3:0] S_DIV     = 4'd8;
    localparam logic [3:0] S_BLEND   = 4'd9;
    localparam logic [3:0] S_EMIT    = 4'd10;

    // Reflect-101 of an index that lies outside 0..len-1, one fold
    function automatic logic [PW:0] fold(input logic signed [PW-1:0] p, input logic dir,
                                         input logic signed [PW-1:0] len);
        logic signed [PW-1:0] np;
        logic                 nd;
        np = p;
        nd = dir;
        if (len == P_ONE)
            np = P_ZERO;
        else if (p < P_ZERO)
        begin
            np = -p;
            nd = ~dir;
        end
        else
        begin
            np = ((len - P_ONE) <<< 1) - p;
            nd = ~dir;
        end
        return {nd, np};
    endfunction

    // Advance a reflected index by one window tap
    function automatic logic [PW:0] walk(input logic signed [PW-1:0] p, input logic dir,
                                         input logic signed [PW-1:0] len);
        logic signed [PW-1:0] np;
        logic                 nd;
        np = p;
        nd = dir;
        if (len == P_ONE)
            np = P_ZERO;
        else if (dir == DIR_UP)
        begin
            if (p == len - P_ONE)
            begin
                np = p - P_ONE;
                nd = DIR_DOWN;
            end
            else
                np = p + P_ONE;
        end
        else
        begin
            if (p == P_ZERO)
            begin
                np = P_ONE;
                nd = DIR_UP;
            end
            else
                np = p - P_ONE;
        end
        return {nd, np};
    endfunction

    // Frame setup from the configuration block
    logic [WW-1:0]     cfg_w;
    logic [HW-1:0]     cfg_h;
    logic [KW-1:0]     cfg_k;
    logic [CW-1:0]     cfg_total;
    logic [CW-1:0]     cfg_lag;
    logic [AREA_W-1:0] cfg_area;

    // Sequencer and frame state
    logic [3:0]        state_reg, state_next;
    logic              active_reg, active_next;
    logic [WW-1:0]     frm_w_reg;
    logic [HW-1:0]     frm_h_reg;
    logic [KW-1:0]     frm_k_reg;
    logic [CW-1:0]     frm_total_reg;
    logic [CW-1:0]     frm_lag_reg;
    logic [AREA_W-1:0] frm_area_reg;
    logic [CW-1:0]     in_cnt_reg, in_cnt_next;
    logic [CW-1:0]     out_cnt_reg, out_cnt_next;
    logic [RWW-1:0]    in_row_reg, in_row_next;
    logic [CB-1:0]     in_col_reg, in_col_next;
    logic [RWW-1:0]    out_row_reg, out_row_next;
    logic [CB-1:0]     out_col_reg, out_col_next;

    // Accepted item
    logic              item_op_reg;
    pix_word_t         item_pix_reg;
    logic [7:0]        item_mask_reg;

    // Window walk
    logic signed [PW-1:0] row_p_reg, row_p_next;
    logic signed [PW-1:0] col_p_reg, col_p_next;
    logic signed [PW-1:0] col0_reg, col0_next;
    logic                 row_dir_reg, row_dir_next;
    logic                 col_dir_reg, col_dir_next;
    logic                 col0_dir_reg, col0_dir_next;
    logic [KW-1:0]        dx_reg, dx_next;
    logic [KW-1:0]        dy_reg, dy_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic                 rd_pend_reg, rd_pend_next;
    pix_word_t            pix_reg, pix_next;

    // Output register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_red_reg, out_green_reg, out_blue_reg;
    logic       out_end_reg;
    logic       load_out;

    // Combinational helpers
    logic                 accept;
    logic                 frame_start;
    logic                 store_ok;
    logic                 emit_ok;
    logic                 last_out;
    logic                 row_in, col_in;
    logic signed [PW-1:0] len_w, len_h;
    logic [KW-1:0]        half;
    logic [PW:0]          row_fold, col_fold, row_step, col_step;
    logic [WW-1:0]        in_col_inc, out_col_inc;

    // Memory and arithmetic units
    logic               mem_we;
    logic               mask_re;
    logic               pix_re;
    logic [7:0]         mask_rdata;
    pix_word_t          pix_rdata;
    logic               div_start;
    logic               div_done;
    logic [ALPHA_W-1:0] div_quot;
    logic               blend_start;
    logic               blend_done;
    logic [7:0]         blend_red, blend_green, blend_blue;

    mbab_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .frame_w     (cfg_w),
        .frame_h     (cfg_h),
        .frame_k     (cfg_k),
        .frame_total (cfg_total),
        .frame_lag   (cfg_lag),
        .frame_area  (cfg_area)
    );

    // Ring of recent rows: slot is the low row bits, then the column
    mbab_line_store #(
        .ADDR_W (ADDR_W)
    ) u_line_store (
        .clk        (clk),
        .we         (mem_we),
        .waddr      ({in_row_reg[RB-1:0], in_col_reg}),
        .mask_wdata (item_mask_reg),
        .pix_wdata  (item_pix_reg),
        .mask_re    (mask_re),
        .mask_raddr ({row_p_reg[RB-1:0], col_p_reg[CB-1:0]}),
        .mask_rdata (mask_rdata),
        .pix_re     (pix_re),
        .pix_raddr  ({out_row_reg[RB-1:0], out_col_reg}),
        .pix_rdata  (pix_rdata)
    );

    mbab_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ((NUM_W'(sum_reg) << 1) + NUM_W'(frm_area_reg)),
        .den   (DEN_W'(frm_area_reg) << 1),
        .done  (div_done),
        .quot  (div_quot)
    );

    mbab_blend u_blend (
        .clk   (clk),
        .rst_n (rst_n),
        .start (blend_start),
        .alpha (div_quot),
        .pix   (pix_reg),
        .done  (blend_done),
        .red   (blend_red),
        .green (blend_green),
        .blue  (blend_blue)
    );

    assign pixels.ready = (state_reg == S_IDLE);
    assign accept       = pixels.valid & pixels.ready;

    assign len_w    = $signed(PW'(frm_w_reg));
    assign len_h    = $signed(PW'(frm_h_reg));
    assign half     = frm_k_reg >> 1;
    assign row_in   = (row_p_reg >= P_ZERO) && (row_p_reg < len_h);
    assign col_in   = (col_p_reg >= P_ZERO) && (col_p_reg < len_w);
    assign row_fold = fold(row_p_reg, row_dir_reg, len_h);
    assign col_fold = fold(col_p_reg, col_dir_reg, len_w);
    assign row_step = walk(row_p_reg, row_dir_reg, len_h);
    assign col_step = walk(col_p_reg, col_dir_reg, len_w);

    assign in_col_inc  = WW'(in_col_reg) + WW'(1);
    assign out_col_inc = WW'(out_col_reg) + WW'(1);

    assign frame_start = (item_op_reg == OP_PIXEL) && !active_reg;
    assign store_ok    = (item_op_reg == OP_PIXEL) && (in_cnt_reg < frm_total_reg);
    // Emit once the window below this output is in, or the frame is complete
    assign emit_ok     = (out_cnt_reg < frm_total_reg) &&
                         ((in_cnt_reg >= frm_total_reg) ||
                          ((CW+1)'(out_cnt_reg) + (CW+1)'(frm_lag_reg) <
                           (CW+1)'(in_cnt_reg)));
    assign last_out    = (out_cnt_reg + CW'(1) == frm_total_reg);
    assign load_out    = (state_reg == S_EMIT) && (!out_valid_reg || results.ready);

    always_comb
    begin
        state_next    = state_reg;
        active_next   = active_reg;
        in_cnt_next   = in_cnt_reg;
        out_cnt_next  = out_cnt_reg;
        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        row_p_next    = row_p_reg;
        col_p_next    = col_p_reg;
        col0_next     = col0_reg;
        row_dir_next  = row_dir_reg;
        col_dir_next  = col_dir_reg;
        col0_dir_next = col0_dir_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        rd_pend_next  = 1'b0;
        pix_next      = pix_reg;
        mem_we        = 1'b0;
        mask_re       = 1'b0;
        pix_re        = 1'b0;
        div_start     = 1'b0;
        blend_start   = 1'b0;

        // Mask taps land in the cycle after their read
        if (state_reg == S_REFL)
            sum_next = '0;
        else if (rd_pend_reg)
            sum_next = sum_reg + SUM_W'(mask_rdata);
        else
            sum_next = sum_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (pixels.opcode == OP_FLUSH && !active_reg)
                        state_next = S_IDLE;
                    else if (pixels.opcode == OP_PIXEL && !active_reg)
                        state_next = S_START;
                    else
                        state_next = S_STORE;
                end
            end

            S_START:
            begin
                active_next  = 1'b1;
                in_cnt_next  = '0;
                out_cnt_next = '0;
                in_row_next  = '0;
                in_col_next  = '0;
                out_row_next = '0;
                out_col_next = '0;
                state_next   = S_STORE;
            end

            S_STORE:
            begin
                // Surplus pixels and flushes store nothing
                if (store_ok)
                begin
                    mem_we      = 1'b1;
                    in_cnt_next = in_cnt_reg + CW'(1);
                    if (in_col_inc == frm_w_reg)
                    begin
                        in_col_next = '0;
                        in_row_next = in_row_reg + RWW'(1);
                    end
                    else
                        in_col_next = in_col_reg + CB'(1);
                end
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                if (emit_ok)
                begin
                    row_p_next   = $signed(PW'(out_row_reg)) - $signed(PW'(half));
                    col_p_next   = $signed(PW'(out_col_reg)) - $signed(PW'(half));
                    row_dir_next = DIR_UP;
                    col_dir_next = DIR_UP;
                    state_next   = S_REFL;
                end
                else
                    state_next = S_IDLE;
            end

            S_REFL:
            begin
                // Fold the window corner back into the frame
                if (!row_in)
                    {row_dir_next, row_p_next} = row_fold;
                if (!col_in)
                    {col_dir_next, col_p_next} = col_fold;
                if (row_in && col_in)
                begin
                    col0_next     = col_p_reg;
                    col0_dir_next = col_dir_reg;
                    dx_next       = '0;
                    dy_next       = '0;
                    state_next    = S_ACC;
                end
            end

            S_ACC:
            begin
                mask_re      = 1'b1;
                rd_pend_next = 1'b1;
                if (dx_reg == frm_k_reg - KW'(1))
                begin
                    dx_next      = '0;
                    col_p_next   = col0_reg;
                    col_dir_next = col0_dir_reg;
                    if (dy_reg == frm_k_reg - KW'(1))
                        state_next = S_PIX;
                    else
                    begin
                        dy_next = dy_reg + KW'(1);
                        {row_dir_next, row_p_next} = row_step;
                    end
                end
                else
                begin
                    dx_next = dx_reg + KW'(1);
                    {col_dir_next, col_p_next} = col_step;
                end
            end

            S_PIX:
            begin
                pix_re     = 1'b1;
                state_next = S_LOADPIX;
            end

            S_LOADPIX:
            begin
                pix_next   = pix_rdata;
                div_start  = 1'b1;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    blend_start = 1'b1;
                    state_next  = S_BLEND;
                end
            end

            S_BLEND:
            begin
                if (blend_done)
                    state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (load_out)
                begin
                    out_cnt_next = out_cnt_reg + CW'(1);
                    if (out_col_inc == frm_w_reg)
                    begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + RWW'(1);
                    end
                    else
                        out_col_next = out_col_reg + CB'(1);
                    // Last output closes the frame
                    if (last_out)
                        active_next = 1'b0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= 1'b0;
            in_cnt_reg    <= '0;
            out_cnt_reg   <= '0;
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            in_cnt_reg    <= in_cnt_next;
            out_cnt_reg   <= out_cnt_next;
            in_row_reg    <= in_row_next;
            in_col_reg    <= in_col_next;
            out_row_reg   <= out_row_next;
            out_col_reg   <= out_col_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_op_reg   <= pixels.opcode;
            item_pix_reg  <= {pixels.orig_red, pixels.orig_green, pixels.orig_blue,
                              pixels.fill_red, pixels.fill_green, pixels.fill_blue};
            item_mask_reg <= pixels.mask_value;
        end
        // Latch the frame geometry on its first pixel
        if (state_reg == S_START && frame_start)
        begin
            frm_w_reg     <= cfg_w;
            frm_h_reg     <= cfg_h;
            frm_k_reg     <= cfg_k;
            frm_total_reg <= cfg_total;
            frm_lag_reg   <= cfg_lag;
            frm_area_reg  <= cfg_area;
        end
        row_p_reg    <= row_p_next;
        col_p_reg    <= col_p_next;
        col0_reg     <= col0_next;
        row_dir_reg  <= row_dir_next;
        col_dir_reg  <= col_dir_next;
        col0_dir_reg <= col0_dir_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        sum_reg      <= sum_next;
        pix_reg      <= pix_next;
        if (load_out)
        begin
            out_red_reg   <= blend_red;
            out_green_reg <= blend_green;
            out_blue_reg  <= blend_blue;
            out_end_reg   <= last_out;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.out_red   = out_red_reg;
    assign results.out_green = out_green_reg;
    assign results.out_blue  = out_blue_reg;
    assign results.frame_end = out_end_reg;

endmodule

[hw/rtl/mbab_checker.sv]
module mbab_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       pix_valid,
    input logic       pix_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] res_red,
    input logic [7:0] res_green,
    input logic [7:0] res_blue,
    input logic       res_frame_end
);

    // Hold a result until it is taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped before it was taken");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=>
            $stable(res_red) && $stable(res_green) && $stable(res_blue) &&
            $stable(res_frame_end))
        else $error("stalled result changed");

    // Input handshake lines stay known once out of reset
    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({pix_valid, pix_ready}))
        else $error("input handshake unknown");

    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !res_valid)
        else $error("result shown during reset");

endmodule

bind masked_border_alpha_blend mbab_checker u_mbab_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .pix_valid     (pixels.valid),
    .pix_ready     (pixels.ready),
    .res_valid     (results.valid),
    .res_ready     (results.ready),
    .res_red       (results.out_red),
    .res_green     (results.out_green),
    .res_blue      (results.out_blue),
    .res_frame_end (results.frame_end)
);
